// ===== design/ycc2rgb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ycc2rgb_pkg
// Shared types, constants and helpers of the YCbCr to RGB pixel packer.
// ----------------------------------------------------------------------------
package ycc2rgb_pkg;

  // internal signed width of the channel sums (covers +-8191)
  localparam int unsigned SumW = 14;

  localparam logic [7:0]      AlphaByte  = 8'hFF;
  localparam logic [7:0]      ChanMax    = 8'd255;
  localparam logic [SumW-1:0] LumaOffset = SumW'(128);
  localparam logic [2:0]      CountFour  = 3'd4;
  localparam logic [2:0]      CountThree = 3'd3;

  // output byte order
  typedef enum logic [1:0] {
    FMT_BGRA = 2'd0,
    FMT_RGBA = 2'd1,
    FMT_BGR  = 2'd2,
    FMT_RGB  = 2'd3
  } pix_fmt_e;

  typedef logic signed [SumW-1:0] chan_sum_t;

  typedef struct packed {
    logic signed [15:0] y_coeff;
    logic signed [15:0] cb_coeff;
    logic signed [15:0] cr_coeff;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] byte_zero;
    logic [7:0] byte_one;
    logic [7:0] byte_two;
    logic [7:0] byte_three;
    logic [2:0] byte_count;
  } pix_out_t;

  // arithmetic right shift (floor), narrowed to the sum width; shifts are 5 or more
  function automatic chan_sum_t asr_ext(logic signed [15:0] v, int unsigned s);
    logic signed [15:0] t;
    t = v >>> s;
    return chan_sum_t'(t[SumW-1:0]);
  endfunction

  // saturate a channel sum to 0..255
  function automatic logic [7:0] clamp8(chan_sum_t v);
    logic [7:0] r;
    if (v < 0) begin
      r = 8'd0;
    end else if (v > chan_sum_t'({1'b0, ChanMax})) begin
      r = ChanMax;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

endpackage

// ===== design/ycbcr_to_rgb_pixel_pack.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ycbcr_to_rgb_pixel_pack
// Converts 11.5 fixed-point YCbCr pixels, one per cycle unless the output
// stalls, to clamped 8-bit RGB and packs them as BGRA, RGBA, BGR or RGB.
// ----------------------------------------------------------------------------
//  channel | handshake                  | payload
//  --------+----------------------------+--------------------------
//  in      | in_valid_i / in_stall_o    | in_pixel_i  (pix_in_t)
//  out     | out_valid_o / out_stall_i  | out_pixel_o (pix_out_t)
//  cfg     | cfg_valid_i / cfg_ready_o  | cfg_data_i  (pixel format)
//
// Three register stages: partial shift-add sums, channel sums, clamp and pack
// into the output register. One pixel per cycle unless the output stalls.
// Each stage advances when the stage after it is empty or moving, so a stall
// on the output fills bubbles first and never drops or repeats a request.
// Reset clears the valid bits and sets the format to BGRA.
// ----------------------------------------------------------------------------
module ycbcr_to_rgb_pixel_pack (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  ycc2rgb_pkg::pix_in_t  in_pixel_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output ycc2rgb_pkg::pix_out_t out_pixel_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_data_i
);
  import ycc2rgb_pkg::*;

  pix_fmt_e fmt_q;

  // stage one: partial sums
  logic      s1_valid_q;
  chan_sum_t s1_y_q, s1_rp0_q, s1_crt_q, s1_gcb_q, s1_gcr_q, s1_bp0_q, s1_bp1_q;
  chan_sum_t s1_y_d, s1_rp0_d, s1_crt_d, s1_gcb_d, s1_gcr_d, s1_bp0_d, s1_bp1_d;

  // stage two: channel sums
  logic      s2_valid_q;
  chan_sum_t s2_r_q, s2_g_q, s2_b_q;
  chan_sum_t s2_r_d, s2_g_d, s2_b_d;

  // stage three: output register
  logic      s3_valid_q;
  pix_out_t  s3_pix_q, s3_pix_d;

  logic adv3, adv2, adv1;

  // advance chain back from the output
  assign adv3 = !s3_valid_q || !out_stall_i;
  assign adv2 = !s2_valid_q || adv3;
  assign adv1 = !s1_valid_q || adv2;

  assign in_stall_o  = !adv1;
  assign out_valid_o = s3_valid_q;
  assign out_pixel_o = s3_pix_q;
  assign cfg_ready_o = 1'b1;

  // format register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= FMT_BGRA;
    end else if (cfg_valid_i && cfg_ready_o) begin
      fmt_q <= pix_fmt_e'(cfg_data_i);
    end
  end

  // luma offset and shift-add partials
  always_comb begin
    s1_y_d   = asr_ext(in_pixel_i.y_coeff, 5) + LumaOffset;
    s1_rp0_d = asr_ext(in_pixel_i.cr_coeff, 5) + asr_ext(in_pixel_i.cr_coeff, 7)
             + asr_ext(in_pixel_i.cr_coeff, 8);
    s1_crt_d = asr_ext(in_pixel_i.cr_coeff, 11) + asr_ext(in_pixel_i.cr_coeff, 12)
             + asr_ext(in_pixel_i.cr_coeff, 13);
    s1_gcb_d = asr_ext(in_pixel_i.cb_coeff, 7) + asr_ext(in_pixel_i.cb_coeff, 9)
             + asr_ext(in_pixel_i.cb_coeff, 10);
    s1_gcr_d = asr_ext(in_pixel_i.cr_coeff, 6) + asr_ext(in_pixel_i.cr_coeff, 8)
             + asr_ext(in_pixel_i.cr_coeff, 9);
    s1_bp0_d = asr_ext(in_pixel_i.cb_coeff, 5) + asr_ext(in_pixel_i.cb_coeff, 6)
             + asr_ext(in_pixel_i.cb_coeff, 7);
    s1_bp1_d = asr_ext(in_pixel_i.cb_coeff, 11) + asr_ext(in_pixel_i.cb_coeff, 13);
  end

  // channel sums, the cr tail is shared by red and green
  always_comb begin
    s2_r_d = s1_y_q + s1_rp0_q + s1_crt_q;
    s2_g_d = s1_y_q - s1_gcb_q - s1_gcr_q - s1_crt_q;
    s2_b_d = s1_y_q + s1_bp0_q + s1_bp1_q;
  end

  // clamp and pack
  always_comb begin
    logic [7:0] rc, gc, bc;
    rc = clamp8(s2_r_q);
    gc = clamp8(s2_g_q);
    bc = clamp8(s2_b_q);
    s3_pix_d.byte_one = gc;
    case (fmt_q)
      FMT_BGRA: begin
        s3_pix_d.byte_zero  = bc;
        s3_pix_d.byte_two   = rc;
        s3_pix_d.byte_three = AlphaByte;
        s3_pix_d.byte_count = CountFour;
      end
      FMT_RGBA: begin
        s3_pix_d.byte_zero  = rc;
        s3_pix_d.byte_two   = bc;
        s3_pix_d.byte_three = AlphaByte;
        s3_pix_d.byte_count = CountFour;
      end
      FMT_BGR: begin
        s3_pix_d.byte_zero  = bc;
        s3_pix_d.byte_two   = rc;
        s3_pix_d.byte_three = 8'd0;
        s3_pix_d.byte_count = CountThree;
      end
      default: begin
        s3_pix_d.byte_zero  = rc;
        s3_pix_d.byte_two   = bc;
        s3_pix_d.byte_three = 8'd0;
        s3_pix_d.byte_count = CountThree;
      end
    endcase
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (adv1) s1_valid_q <= in_valid_i;
      if (adv2) s2_valid_q <= s1_valid_q;
      if (adv3) s3_valid_q <= s2_valid_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (adv1 && in_valid_i) begin
      s1_y_q   <= s1_y_d;
      s1_rp0_q <= s1_rp0_d;
      s1_crt_q <= s1_crt_d;
      s1_gcb_q <= s1_gcb_d;
      s1_gcr_q <= s1_gcr_d;
      s1_bp0_q <= s1_bp0_d;
      s1_bp1_q <= s1_bp1_d;
    end
    if (adv2 && s1_valid_q) begin
      s2_r_q <= s2_r_d;
      s2_g_q <= s2_g_d;
      s2_b_q <= s2_b_d;
    end
    if (adv3 && s2_valid_q) begin
      s3_pix_q <= s3_pix_d;
    end
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the YCbCr to RGB pixel packer. Pixel requests go
// in through the valid/stall input channel. A tracker class predicts the
// clamped and packed bytes for each accepted request and compares every
// accepted output pixel, field by field, against the oldest prediction.
// Corner pixels run first under the reset format. Random pixels follow in
// segments, and each segment writes a byte order and sets an idling mix.
// ----------------------------------------------------------------------------

import ycc2rgb_pkg::*;

// prediction and checking of packed pixels
class rgb_pack_tracker;
  pix_fmt_e fmt = FMT_BGRA;
  pix_out_t pending_pixels [$];
  int       errors = 0;

  task report(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  // floor division by 2^s on a signed coefficient
  function int floor_shr(logic signed [15:0] v, int unsigned s);
    return int'(v >>> s);
  endfunction

  function logic [7:0] sat_byte(int v);
    if (v < 0) begin
      return 8'd0;
    end
    if (v > 255) begin
      return 8'd255;
    end
    return v[7:0];
  endfunction

  function pix_out_t pack_pixel(pix_in_t p);
    int luma, red, grn, blu;
    logic [7:0] rc, gc, bc;
    pix_out_t o;
    luma = floor_shr(p.y_coeff, 5) + int'(LumaOffset);
    // red: cr * 1.402
    red = luma + floor_shr(p.cr_coeff, 5) + floor_shr(p.cr_coeff, 7)
        + floor_shr(p.cr_coeff, 8) + floor_shr(p.cr_coeff, 11)
        + floor_shr(p.cr_coeff, 12) + floor_shr(p.cr_coeff, 13);
    // green: cb * 0.344 and cr * 0.714 subtracted
    grn = luma - (floor_shr(p.cb_coeff, 7) + floor_shr(p.cb_coeff, 9)
        + floor_shr(p.cb_coeff, 10))
        - (floor_shr(p.cr_coeff, 6) + floor_shr(p.cr_coeff, 8)
        + floor_shr(p.cr_coeff, 9) + floor_shr(p.cr_coeff, 11)
        + floor_shr(p.cr_coeff, 12) + floor_shr(p.cr_coeff, 13));
    // blue: cb * 1.77
    blu = luma + floor_shr(p.cb_coeff, 5) + floor_shr(p.cb_coeff, 6)
        + floor_shr(p.cb_coeff, 7) + floor_shr(p.cb_coeff, 11)
        + floor_shr(p.cb_coeff, 13);
    rc = sat_byte(red);
    gc = sat_byte(grn);
    bc = sat_byte(blu);
    // byte order
    if (fmt == FMT_BGRA || fmt == FMT_BGR) begin
      o.byte_zero = bc;
      o.byte_two  = rc;
    end else begin
      o.byte_zero = rc;
      o.byte_two  = bc;
    end
    o.byte_one = gc;
    if (fmt == FMT_BGRA || fmt == FMT_RGBA) begin
      o.byte_three = AlphaByte;
      o.byte_count = CountFour;
    end else begin
      o.byte_three = 8'd0;
      o.byte_count = CountThree;
    end
    return o;
  endfunction

  function void note_pixel(pix_in_t p);
    pending_pixels.push_back(pack_pixel(p));
  endfunction

  function int pending();
    return pending_pixels.size();
  endfunction

  task check_pixel(pix_out_t got);
    pix_out_t want;
    if (pending_pixels.size() == 0) begin
      report($sformatf("output pixel %h with no request waiting", got));
    end else begin
      want = pending_pixels.pop_front();
      if (got.byte_zero != want.byte_zero)
        report($sformatf("byte_zero got %h want %h", got.byte_zero, want.byte_zero));
      if (got.byte_one != want.byte_one)
        report($sformatf("byte_one got %h want %h", got.byte_one, want.byte_one));
      if (got.byte_two != want.byte_two)
        report($sformatf("byte_two got %h want %h", got.byte_two, want.byte_two));
      if (got.byte_three != want.byte_three)
        report($sformatf("byte_three got %h want %h", got.byte_three, want.byte_three));
      if (got.byte_count != want.byte_count)
        report($sformatf("byte_count got %0d want %0d", got.byte_count, want.byte_count));
    end
  endtask
endclass

module tb_top;

  localparam int CycleLimit   = 300000;
  localparam int HoldCycles   = 200;
  localparam int NumSegments  = 12;
  localparam int SegmentItems = 162;
  localparam int DrainCycles  = 8;

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  pix_in_t  in_pixel_i;
  logic     out_valid_o;
  logic     out_stall_i;
  pix_out_t out_pixel_o;
  logic     cfg_valid_i;
  logic     cfg_ready_o;
  logic [1:0] cfg_data_i;

  rgb_pack_tracker tracker;

  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  bit hold_req     = 1'b0;
  int cycle_count  = 0;

  ycbcr_to_rgb_pixel_pack dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_pixel_i  (in_pixel_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_pixel_o (out_pixel_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // output monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      tracker.check_pixel(out_pixel_o);
    end
  end

  // receiver: random stall, or one long hold-off when asked
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HoldCycles - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < rcv_idle_pct);
      end
    end
  end

  function automatic pix_in_t pixel_of(int y, int cb, int cr);
    pix_in_t p;
    p.y_coeff  = 16'(y);
    p.cb_coeff = 16'(cb);
    p.cr_coeff = 16'(cr);
    return p;
  endfunction

  // mostly in-range values, some full range, some extremes
  function automatic logic signed [15:0] rand_coeff();
    logic signed [15:0] v;
    case ($urandom_range(0, 3))
      0, 1: begin
        v = 16'($signed({1'b0, 13'($urandom_range(0, 8191))}) - 4096);
      end
      2: begin
        v = 16'($urandom);
      end
      default: begin
        case ($urandom_range(0, 3))
          0:       v = 16'sh7FFF;
          1:       v = 16'sh8000;
          2:       v = 16'sh0000;
          default: v = 16'shFFFF;
        endcase
      end
    endcase
    return v;
  endfunction

  // send one pixel request; called and returns at a falling edge
  task automatic send_pixel(pix_in_t p);
    while (snd_idle_pct != 0 && $urandom_range(0, 99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_pixel_i <= p;
    do @(posedge clk_i); while (in_stall_o);
    tracker.note_pixel(p);
    @(negedge clk_i);
  endtask

  // wait until every predicted pixel has come out
  task automatic drain();
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // format register write, only while the block is idle
  task automatic write_format(pix_fmt_e f);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= f;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.fmt = f;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // stimulus
  initial begin
    pix_in_t  corner_px [$];
    pix_fmt_e seg_fmt;
    tracker = new;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_pixel_i  = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // corner pixels under the reset format
    corner_px.push_back(pixel_of(0, 0, 0));
    corner_px.push_back(pixel_of(32767, 32767, 32767));
    corner_px.push_back(pixel_of(-32768, -32768, -32768));
    corner_px.push_back(pixel_of(32767, -32768, -32768));
    corner_px.push_back(pixel_of(-32768, 32767, 32767));
    corner_px.push_back(pixel_of(0, 32767, 0));
    corner_px.push_back(pixel_of(0, -32768, 0));
    corner_px.push_back(pixel_of(0, 0, 32767));
    corner_px.push_back(pixel_of(0, 0, -32768));
    corner_px.push_back(pixel_of(-1, -1, -1));
    // luma right at and past the clamp limits
    corner_px.push_back(pixel_of(4064, 0, 0));
    corner_px.push_back(pixel_of(4096, 0, 0));
    corner_px.push_back(pixel_of(-4096, 0, 0));
    corner_px.push_back(pixel_of(-4128, 0, 0));
    // shifts of negative values round down
    corner_px.push_back(pixel_of(-31, -33, -31));
    corner_px.push_back(pixel_of(31, 33, -65));
    corner_px.push_back(pixel_of('h5555, 'hAAAA, 'h5555));
    corner_px.push_back(pixel_of('hAAAA, 'h5555, 'hAAAA));
    corner_px.push_back(pixel_of(0, -4096, 4096));
    corner_px.push_back(pixel_of(0, 4096, -4096));
    snd_idle_pct = 20;
    rcv_idle_pct = 20;
    foreach (corner_px[i]) send_pixel(corner_px[i]);
    drain();

    // random segments, each writes a format and sets an idling mix
    for (int seg = 0; seg < NumSegments; seg++) begin
      seg_fmt = pix_fmt_e'(2'((seg * 3 + 3) % 4));
      write_format(seg_fmt);
      if (seg < 4) begin
        snd_idle_pct = 30;
        rcv_idle_pct = 70;
      end else if (seg < 8) begin
        snd_idle_pct = 70;
        rcv_idle_pct = 30;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      // long output hold-off while requests keep coming
      if (seg == 9) hold_req = 1'b1;
      for (int n = 0; n < SegmentItems; n++) begin
        send_pixel(pixel_of(rand_coeff(), rand_coeff(), rand_coeff()));
      end
      drain();
    end

    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/ycc2rgb_pkg.sv
design/ycbcr_to_rgb_pixel_pack.sv
verif/tb_top.sv
